>>> rtl/banked_bump_allocator_macros.svh
// assertion macros for the banked bump allocator checker
`ifndef BANKED_BUMP_ALLOCATOR_MACROS_SVH
`define BANKED_BUMP_ALLOCATOR_MACROS_SVH

// same-cycle implication, muted during reset
`define BBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bba check failed");

// next-cycle implication, muted during reset
`define BBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bba check failed");

// same-cycle implication, also checked across reset
`define BBA_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("bba check failed");

`endif

>>> rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

  // bank counts
  localparam int NUM_BANKS = 2;
  localparam int MAX_BANKS = 2;
  localparam int IDX_W     = 1;
  localparam int CNT_W     = 2;

  // field widths
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 24;
  localparam int ALIGN_W = 17;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 3;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BANK0_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK0_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BANK1_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BANK1_LIMIT = 3'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SIZE_W-1:0]  request_size;
    logic               bank_index;
    logic [ALIGN_W-1:0] alignment;
    logic [ADDR_W-1:0]  free_address;
  } req_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic              out_of_memory;
    logic              bad_free;
  } rsp_item_t;

  typedef struct packed {
    logic [MAX_BANKS-1:0][ADDR_W-1:0] base;
    logic [MAX_BANKS-1:0][ADDR_W-1:0] limit;
  } bank_cfg_t;

  typedef struct packed {
    logic [MAX_BANKS-1:0]             wen;
    logic [MAX_BANKS-1:0][ADDR_W-1:0] wdata;
  } ptr_wr_t;

endpackage

`default_nettype wire

>>> rtl/banked_bump_allocator.sv
// Banked bump allocator: one bump pointer per bank, with base and limit set through the
// write port. A request beat carries an allocate, a free or a pointer reset; each gives
// exactly one response beat. A request is held in the input register, where the adds,
// mask and limit compare on the bank pointers decide the response and the pointer
// update, both written at the same edge into the response register and the pointers.
// One request is taken every cycle while the response side keeps up, since the pointer
// read-modify-write closes within the compute stage. Pointers read as zero after rst
// until a request writes them; a reset request copies the bases in.
`default_nettype none

module banked_bump_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire bba_pkg::req_item_t            req,
  output logic                               rsp_valid,
  input  wire logic                          rsp_ready,
  output bba_pkg::rsp_item_t                 rsp,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bba_pkg::ADDR_W-1:0]    cfg_data
);

  bba_pkg::bank_cfg_t                        cfg;
  bba_pkg::req_item_t                        stage;
  logic                                      stage_valid;
  logic                                      advance;
  logic [bba_pkg::MAX_BANKS-1:0][bba_pkg::ADDR_W-1:0] pointer;
  bba_pkg::rsp_item_t                        result;
  bba_pkg::ptr_wr_t                          ptr_wr;

  // configuration registers
  bba_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake between stages
  assign advance   = stage_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !stage_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      stage <= req;
    end
  end

  // pointer compute
  bba_alloc_unit u_alloc (
    .item    (stage),
    .cfg     (cfg),
    .pointer (pointer),
    .result  (result),
    .ptr_wr  (ptr_wr)
  );

  // bank pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      pointer <= '0;
    end else if (advance) begin
      for (int i = 0; i < bba_pkg::MAX_BANKS; i++) begin
        if (ptr_wr.wen[i]) begin
          pointer[i] <= ptr_wr.wdata[i];
        end
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bba_cfg_regs.sv
`default_nettype none

module bba_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bba_pkg::ADDR_W-1:0]      cfg_data,
  output bba_pkg::bank_cfg_t                   cfg
);

  // bank base and limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bba_pkg::REG_BANK0_BASE: begin
          cfg.base[0] <= cfg_data;
        end
        bba_pkg::REG_BANK0_LIMIT: begin
          cfg.limit[0] <= cfg_data;
        end
        bba_pkg::REG_BANK1_BASE: begin
          cfg.base[1] <= cfg_data;
        end
        bba_pkg::REG_BANK1_LIMIT: begin
          cfg.limit[1] <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/bba_alloc_unit.sv
`default_nettype none

module bba_alloc_unit (
  input  wire bba_pkg::req_item_t                                item,
  input  wire bba_pkg::bank_cfg_t                                cfg,
  input  wire logic [bba_pkg::MAX_BANKS-1:0][bba_pkg::ADDR_W-1:0] pointer,
  output bba_pkg::rsp_item_t                                     result,
  output bba_pkg::ptr_wr_t                                       ptr_wr
);

  logic [bba_pkg::ADDR_W-1:0]  sel_ptr;
  logic [bba_pkg::ADDR_W-1:0]  sel_limit;
  logic                        bank_ok;
  logic [bba_pkg::ALIGN_W-1:0] mask;
  logic [bba_pkg::ADDR_W+1:0]  align_eff;
  logic [bba_pkg::ADDR_W:0]    aligned;
  logic [bba_pkg::ADDR_W+1:0]  need;
  logic                        fits;
  logic [bba_pkg::ADDR_W-1:0]  bumped;
  logic [bba_pkg::CNT_W-1:0]   count;
  logic                        free_bad;

  // allocate: round up, then fit test against the bank limit
  assign sel_ptr   = pointer[item.bank_index];
  assign sel_limit = cfg.limit[item.bank_index];
  assign bank_ok   = int'(item.bank_index) < bba_pkg::NUM_BANKS;
  assign mask      = (item.alignment == '0) ? '0 : item.alignment - 17'd1;
  assign align_eff = (item.alignment == '0) ? 34'd1 : 34'(item.alignment);
  assign aligned   = ({1'b0, sel_ptr} + 33'(mask)) & ~33'(mask);
  assign need      = 34'(aligned) + 34'(item.request_size) + align_eff;
  assign fits      = bank_ok && (need <= 34'(sel_limit));
  assign bumped    = aligned[bba_pkg::ADDR_W-1:0] + 32'(item.request_size);

  // free: count limits at or below the address
  always_comb begin
    count = '0;
    for (int i = 0; i < bba_pkg::MAX_BANKS; i++) begin
      if (i < bba_pkg::NUM_BANKS && item.free_address >= cfg.limit[i]) begin
        count = count + 2'd1;
      end
    end
  end

  assign free_bad = int'(count) >= bba_pkg::NUM_BANKS;

  // result and pointer update per kind
  always_comb begin
    result = '0;
    ptr_wr = '0;
    case (item.kind)
      bba_pkg::KIND_ALLOC: begin
        if (fits) begin
          result.block_address = aligned[bba_pkg::ADDR_W-1:0];
          ptr_wr.wen[item.bank_index]   = 1'b1;
          ptr_wr.wdata[item.bank_index] = bumped;
        end else begin
          result.out_of_memory = 1'b1;
        end
      end
      bba_pkg::KIND_FREE: begin
        if (free_bad) begin
          result.bad_free = 1'b1;
        end else begin
          ptr_wr.wen[count[bba_pkg::IDX_W-1:0]]   = 1'b1;
          ptr_wr.wdata[count[bba_pkg::IDX_W-1:0]] = item.free_address;
        end
      end
      bba_pkg::KIND_RESET: begin
        for (int i = 0; i < bba_pkg::MAX_BANKS; i++) begin
          if (i < bba_pkg::NUM_BANKS) begin
            ptr_wr.wen[i]   = 1'b1;
            ptr_wr.wdata[i] = cfg.base[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/bba_checker.sv
`default_nettype none
`include "banked_bump_allocator_macros.svh"

module bba_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire bba_pkg::rsp_item_t rsp
);

  // a stalled response beat stays offered
  `BBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

  // a beat never flags both failures
  `BBA_ASSERT_NOW(a_flags_excl, rsp_valid, !(rsp.out_of_memory && rsp.bad_free))

  // a nonzero address only comes from a successful allocate
  `BBA_ASSERT_NOW(a_addr_ok, rsp_valid && (|rsp.block_address), !rsp.out_of_memory && !rsp.bad_free)

  // reset leaves no response pending
  `BBA_ASSERT_ALWAYS(a_rst_clear, $past(rst), !rsp_valid)

endmodule

bind banked_bump_allocator bba_checker u_checker (.*);

`default_nettype wire
